FILE: rtl/core/cstw_pkg.sv
package cstw_pkg;

  localparam int PlainDepthDef = 8;
  localparam int TimedDepthDef = 8;

  localparam logic [1:0] OP_WAIT   = 2'd0;
  localparam logic [1:0] OP_SIGNAL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] K_GRANTED  = 3'd0;
  localparam logic [2:0] K_BLOCKED  = 3'd1;
  localparam logic [2:0] K_WOKEN    = 3'd2;
  localparam logic [2:0] K_TIMEOUT  = 3'd3;
  localparam logic [2:0] K_SIG_DONE = 3'd4;
  localparam logic [2:0] K_IDLE     = 3'd5;
  localparam logic [2:0] K_FULL     = 3'd6;
  localparam logic [2:0] K_TICK     = 3'd7;

  localparam logic CFG_INIT_COUNT = 1'b0;
  localparam logic CFG_IDLE_ID    = 1'b1;

  // controller to datapath commands
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_LATCH    = 4'd1,  // capture transaction
    CMD_WAIT_DEC = 4'd2,  // wait: decide and emit
    CMD_PUSH_P   = 4'd3,  // push untimed waiter, emit blocked
    CMD_SCAN     = 4'd4,  // advance timed insert scan one entry
    CMD_SHIFT_IN = 4'd5,  // shift one entry up during insert
    CMD_PLACE    = 4'd6,  // place timed entry, emit blocked
    CMD_WAKE     = 4'd7,  // signal wakes one waiter
    CMD_REMOVE   = 4'd8,  // shift one entry down
    CMD_FINISH_R = 4'd9,  // finish removal (hand-over / tick)
    CMD_REMAIN   = 4'd10, // add remainder, emit signal done
    CMD_TICK_DEC = 4'd11, // decrement head delay
    CMD_TICK_CHK = 4'd12, // expire head or emit tick done
    CMD_SIG_NEG  = 4'd13, // emit refused / zero handling
    CMD_SCAN_END = 4'd14  // hold insert position, start shift from the tail
  } cmd_t;

  typedef struct packed {
    logic is_wait;
    logic is_sig;
    logic is_tick;
    logic wait_grant;  // count positive or idle thread or queue full
    logic plain_wait;
    logic scan_more;
    logic shift_more;
    logic wake_avail;
    logic rem_pos;
    logic sig_neg;
    logic sig_zero;
    logic timed_any;
    logic head_zero;
    logic remove_more;
    logic from_timed;
  } stat_t;

endpackage

FILE: rtl/core/cstw_datapath.sv
module cstw_datapath #(
  parameter int PLAIN_DEPTH = 8,
  parameter int TIMED_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_index,
  input  logic [14:0]          cfg_wdata_init,
  input  logic [7:0]           cfg_wdata_idle,
  input  logic [1:0]           in_operation,
  input  logic [7:0]           in_thread_id,
  input  logic [15:0]          in_max_wait,
  input  logic signed [15:0]   in_release_count,
  input  cstw_pkg::cmd_t       cmd,
  output cstw_pkg::stat_t      stat,
  output logic                 out_valid,
  output logic [2:0]           out_kind,
  output logic [7:0]           out_woken_thread,
  output logic signed [15:0]   out_signal_return,
  output logic signed [15:0]   out_count_after,
  output logic                 out_last
);
  import cstw_pkg::*;

  localparam int PW = (PLAIN_DEPTH > 1) ? $clog2(PLAIN_DEPTH) : 1;
  localparam int TW = (TIMED_DEPTH > 1) ? $clog2(TIMED_DEPTH) : 1;
  localparam int PC = $clog2(PLAIN_DEPTH + 1);
  localparam int TC = $clog2(TIMED_DEPTH + 1);

  logic [7:0]         idle_r;
  logic signed [15:0] cnt_r, cnt_nxt;
  logic [7:0]         pq_r [PLAIN_DEPTH];
  logic [PW-1:0]      phead_r;
  logic [PC-1:0]      pused_r;
  logic [7:0]         tid_r [TIMED_DEPTH];
  logic [15:0]        tdl_r [TIMED_DEPTH];
  logic [TC-1:0]      tused_r;

  logic [1:0]         op_r;
  logic [7:0]         thr_r;
  logic [15:0]        t_r;
  logic signed [15:0] amt_r;
  logic [15:0]        rem_r;
  logic [15:0]        woken_r;
  logic [TC-1:0]      pos_r;   // scan/shift pointer
  logic [15:0]        rest_r;  // delay handed over
  logic               htimed_r;

  logic               ov_r;
  logic [2:0]         ok_r;
  logic [7:0]         ow_r;
  logic signed [15:0] os_r;
  logic signed [15:0] oc_r;
  logic               ol_r;

  logic [PW-1:0] ptail;
  logic [PW:0]   psum;
  logic [TW-1:0] posi;
  logic [TW-1:0] posm1;
  logic [16:0]   hsum;
  logic signed [16:0] csum;
  logic          emit;

  assign psum  = {1'b0, phead_r} + PW'(pused_r);
  assign ptail = (psum >= (PW+1)'(PLAIN_DEPTH)) ? PW'(psum - (PW+1)'(PLAIN_DEPTH))
                                               : psum[PW-1:0];
  assign posi  = pos_r[TW-1:0];
  assign posm1 = posi - TW'(1);
  assign hsum  = {1'b0, tdl_r[0]} + {1'b0, rest_r};
  assign csum  = 17'(cnt_r) + 17'(signed'({1'b0, rem_r}));

  always_comb begin
    stat.is_wait     = (op_r == OP_WAIT);
    stat.is_sig      = (op_r == OP_SIGNAL);
    stat.is_tick     = (op_r == OP_TICK);
    stat.wait_grant  = (cnt_r > 0) || (thr_r == idle_r) ||
                       ((t_r == 16'd0) ? (pused_r >= PC'(PLAIN_DEPTH))
                                       : (tused_r >= TC'(TIMED_DEPTH)));
    stat.plain_wait  = (t_r == 16'd0);
    stat.scan_more   = (pos_r < tused_r) && (t_r >= tdl_r[posi]);
    stat.shift_more  = (pos_r > 0) && ({1'b0, pos_r} > {1'b0, rest_r[TC-1:0]});
    stat.wake_avail  = (pused_r != 0) || (tused_r != 0);
    stat.rem_pos     = (rem_r != 16'd0);
    stat.sig_neg     = amt_r[15];
    stat.sig_zero    = (amt_r == 16'sd0);
    stat.timed_any   = (tused_r != 0);
    stat.head_zero   = (tdl_r[0] == 16'd0);
    stat.remove_more = (pos_r < tused_r);
    stat.from_timed  = htimed_r;
  end

  assign emit = (cmd == CMD_WAIT_DEC && stat.wait_grant) || (cmd == CMD_PUSH_P) ||
                (cmd == CMD_PLACE) || (cmd == CMD_WAKE) || (cmd == CMD_REMAIN) ||
                (cmd == CMD_SIG_NEG && amt_r[15]) || (cmd == CMD_TICK_CHK);

  function automatic logic signed [15:0] up1(input logic signed [15:0] c);
    up1 = (c == 16'sh7FFF) ? c : c + 16'sd1;
  endfunction
  function automatic logic signed [15:0] dn1(input logic signed [15:0] c);
    dn1 = (c == -16'sh8000) ? c : c - 16'sd1;
  endfunction

  always_comb begin
    cnt_nxt = cnt_r;
    unique case (cmd)
      CMD_WAIT_DEC: if (cnt_r > 0 || thr_r == idle_r) cnt_nxt = dn1(cnt_r);
      CMD_PUSH_P, CMD_PLACE: cnt_nxt = dn1(cnt_r);
      CMD_WAKE: if (amt_r != 16'sd0) cnt_nxt = up1(cnt_r);
      CMD_SIG_NEG: if (!amt_r[15]) cnt_nxt = up1(cnt_r);
      CMD_REMAIN: cnt_nxt = (csum > 17'sd32767) ? 16'sh7FFF : csum[15:0];
      CMD_TICK_CHK: if (tused_r != 0 && tdl_r[0] == 16'd0) cnt_nxt = up1(cnt_r);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r  <= 8'd0;
      cnt_r   <= 16'sd1;
      phead_r <= '0;
      pused_r <= '0;
      tused_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= emit;
      if (cfg_we && cfg_index == {7'd0, CFG_INIT_COUNT})
        cnt_r <= signed'({1'b0, cfg_wdata_init});
      else
        cnt_r <= cnt_nxt;
      if (cfg_we && cfg_index == {7'd0, CFG_IDLE_ID}) idle_r <= cfg_wdata_idle;
      unique case (cmd)
        CMD_LATCH: begin
          op_r    <= in_operation;
          thr_r   <= in_thread_id;
          t_r     <= in_max_wait;
          amt_r   <= in_release_count;
          rem_r   <= in_release_count;
          woken_r <= '0;
          pos_r   <= '0;
        end
        CMD_WAIT_DEC: begin
          if (cnt_r > 0 || thr_r == idle_r ||
              (t_r == 16'd0 && pused_r >= PC'(PLAIN_DEPTH)) ||
              (t_r != 16'd0 && tused_r >= TC'(TIMED_DEPTH))) begin
            ok_r <= (cnt_r > 0) ? K_GRANTED : (thr_r == idle_r) ? K_IDLE : K_FULL;
            ow_r <= thr_r;
            os_r <= '0;
            oc_r <= cnt_nxt;
            ol_r <= 1'b1;
          end
        end
        CMD_PUSH_P: begin
          pq_r[ptail] <= thr_r;
          pused_r <= pused_r + PC'(1);
          ok_r <= K_BLOCKED; ow_r <= thr_r; os_r <= '0;
          oc_r <= cnt_nxt; ol_r <= 1'b1;
        end
        CMD_SCAN: begin
          t_r   <= t_r - tdl_r[posi];
          pos_r <= pos_r + TC'(1);
        end
        CMD_SCAN_END: begin
          rest_r <= 16'(pos_r);
          pos_r  <= tused_r;
        end
        CMD_SHIFT_IN: begin
          // rest_r holds insert position, pos_r walks down from used
          tid_r[posi] <= tid_r[posm1];
          tdl_r[posi] <= tdl_r[posm1];
          pos_r <= pos_r - TC'(1);
        end
        CMD_PLACE: begin
          tid_r[posi] <= thr_r;
          tdl_r[posi] <= t_r;
          if (pos_r < tused_r) tdl_r[TW'(pos_r + TC'(1))] <= tdl_r[posi] - t_r;
          tused_r <= tused_r + TC'(1);
          ok_r <= K_BLOCKED; ow_r <= thr_r; os_r <= '0;
          oc_r <= cnt_nxt; ol_r <= 1'b1;
        end
        CMD_WAKE: begin
          ok_r <= K_WOKEN; os_r <= '0; oc_r <= cnt_nxt; ol_r <= 1'b0;
          if (amt_r != 16'sd0) begin
            rem_r   <= rem_r - 16'd1;
            woken_r <= woken_r + 16'd1;
          end
          if (pused_r != 0) begin
            ow_r    <= pq_r[phead_r];
            phead_r <= (phead_r == PW'(PLAIN_DEPTH - 1)) ? '0 : phead_r + PW'(1);
            pused_r <= pused_r - PC'(1);
            htimed_r <= 1'b0;
          end else begin
            ow_r     <= tid_r[0];
            rest_r   <= tdl_r[0];
            pos_r    <= TC'(1);
            htimed_r <= 1'b1;
          end
        end
        CMD_REMOVE: begin
          tid_r[posm1] <= tid_r[posi];
          tdl_r[posm1] <= tdl_r[posi];
          pos_r <= pos_r + TC'(1);
        end
        CMD_FINISH_R: begin
          tused_r <= tused_r - TC'(1);
          htimed_r <= 1'b0;
          if (op_r == OP_SIGNAL && tused_r > TC'(1))
            tdl_r[0] <= hsum[16] ? 16'hFFFF : hsum[15:0];
        end
        CMD_REMAIN: begin
          ok_r <= K_SIG_DONE; ow_r <= '0; os_r <= woken_r;
          oc_r <= cnt_nxt; ol_r <= 1'b1;
        end
        CMD_SIG_NEG: begin
          if (amt_r[15]) begin
            ok_r <= K_SIG_DONE; ow_r <= '0; os_r <= amt_r;
            oc_r <= cnt_r; ol_r <= 1'b1;
          end
        end
        CMD_TICK_DEC: begin
          if (tused_r != 0 && tdl_r[0] != 16'd0) tdl_r[0] <= tdl_r[0] - 16'd1;
        end
        CMD_TICK_CHK: begin
          os_r <= '0; oc_r <= cnt_nxt;
          if (tused_r != 0 && tdl_r[0] == 16'd0) begin
            ok_r <= K_TIMEOUT; ow_r <= tid_r[0]; ol_r <= 1'b0;
            pos_r <= TC'(1); htimed_r <= 1'b1;
          end else begin
            ok_r <= K_TICK; ow_r <= '0; ol_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = ov_r;
  assign out_kind          = ok_r;
  assign out_woken_thread  = ow_r;
  assign out_signal_return = os_r;
  assign out_count_after   = oc_r;
  assign out_last          = ol_r;

endmodule

FILE: rtl/core/cstw_ctrl.sv
module cstw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  cstw_pkg::stat_t stat,
  output cstw_pkg::cmd_t  cmd
);
  import cstw_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DEC    = 10'b0000000010,
    S_SCAN   = 10'b0000000100,
    S_SHIFT  = 10'b0000001000,
    S_SIG    = 10'b0000010000,
    S_WAKE   = 10'b0000100000,
    S_REMOVE = 10'b0001000000,
    S_REMAIN = 10'b0010000000,
    S_TICK   = 10'b0100000000,
    S_TCHK   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   sig_zero_r, sig_zero_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = CMD_NONE;
    sig_zero_nxt = sig_zero_r;
    unique case (state_r)
      S_IDLE: if (start) begin
        cmd = CMD_LATCH;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        priority if (stat.is_wait) begin
          cmd = CMD_WAIT_DEC;
          priority if (stat.wait_grant) state_nxt = S_IDLE;
          else if (stat.plain_wait) begin
            cmd = CMD_PUSH_P; state_nxt = S_IDLE;
          end else state_nxt = S_SCAN;
        end else if (stat.is_sig) begin
          state_nxt = S_SIG;
        end else if (stat.is_tick) begin
          cmd = CMD_TICK_DEC; state_nxt = S_TICK;
        end else state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_more) cmd = CMD_SCAN;
        else begin
          cmd = CMD_SCAN_END; state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_more) cmd = CMD_SHIFT_IN;
        else begin
          cmd = CMD_PLACE; state_nxt = S_IDLE;
        end
      end
      S_SIG: begin
        sig_zero_nxt = stat.sig_zero;
        priority if (stat.sig_neg) begin
          cmd = CMD_SIG_NEG; state_nxt = S_IDLE;
        end else if (stat.sig_zero) begin
          cmd = CMD_SIG_NEG;
          state_nxt = stat.wake_avail ? S_WAKE : S_REMAIN;
        end else state_nxt = S_WAKE;
      end
      S_WAKE: begin
        if ((sig_zero_r || stat.rem_pos) && stat.wake_avail) begin
          cmd = CMD_WAKE;
          state_nxt = S_REMOVE;
        end else state_nxt = S_REMAIN;
      end
      S_REMOVE: begin
        if (!stat.from_timed) state_nxt = sig_zero_r ? S_REMAIN : S_WAKE;
        else if (stat.remove_more) cmd = CMD_REMOVE;
        else begin
          cmd = CMD_FINISH_R;
          state_nxt = stat.is_tick ? S_TCHK : (sig_zero_r ? S_REMAIN : S_WAKE);
        end
      end
      S_REMAIN: begin
        cmd = CMD_REMAIN;
        sig_zero_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      S_TICK: state_nxt = S_TCHK;
      S_TCHK: begin
        cmd = CMD_TICK_CHK;
        state_nxt = (stat.timed_any && stat.head_zero) ? S_REMOVE : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      sig_zero_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sig_zero_r <= sig_zero_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/core/counting_semaphore_timed_waits.sv
// channel  ports                                              handshake
// in       in_operation in_thread_id in_max_wait               start & !busy
//          in_release_count
// out      out_kind out_woken_thread out_signal_return         out_valid, 1 cycle
//          out_count_after out_last
// cfg      cfg_we cfg_index cfg_wdata                          cfg_we
// An untimed or refused wait ends after its decision; a timed wait scans past
// earlier timed entries, moves later ones up and then places its own entry.
// A refused signal only reports. Otherwise a signal wakes waiters one by one,
// each timed one closing its gap in the list; a tick does so per expired waiter.
// Synchronous reset loads count 1, empties both queues.
// The receiver cannot stall; results leave as they are made.
module counting_semaphore_timed_waits #(
  parameter int PLAIN_DEPTH = cstw_pkg::PlainDepthDef,
  parameter int TIMED_DEPTH = cstw_pkg::TimedDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [7:0]         in_thread_id,
  input  logic [15:0]        in_max_wait,
  input  logic signed [15:0] in_release_count,
  output logic               out_valid,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_woken_thread,
  output logic signed [15:0] out_signal_return,
  output logic signed [15:0] out_count_after,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [14:0]        cfg_wdata
);
  import cstw_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cstw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  cstw_datapath #(.PLAIN_DEPTH(PLAIN_DEPTH), .TIMED_DEPTH(TIMED_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata_init(cfg_wdata), .cfg_wdata_idle(cfg_wdata[7:0]),
    .in_operation(in_operation), .in_thread_id(in_thread_id),
    .in_max_wait(in_max_wait), .in_release_count(in_release_count),
    .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_kind(out_kind), .out_woken_thread(out_woken_thread),
    .out_signal_return(out_signal_return), .out_count_after(out_count_after),
    .out_last(out_last)
  );

endmodule
